// ===== hw/rtl/sbv_pkg.sv =====
// Shared types and constants for the segment box vertex generator.
`timescale 1ns / 1ps
package sbv_pkg;

  // Register indexes on the configuration port
  localparam logic [7:0] REG_HALF_WIDTH = 8'd0;
  localparam logic [7:0] REG_EDGE_CUT   = 8'd1;

  // Segment data that travels along the cell chains
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               neg_x;
    logic               neg_y;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic               trim_s;
    logic               trim_e;
  } side_t;

endpackage

// ===== hw/rtl/segment_box_vertex_generator_top.sv =====
// Segment box vertex generator: unit vector chains, corner products and corner emitter.
`timescale 1ns / 1ps
// Takes one segment per start pulse and emits the eight box corners on
// consecutive cycles, each marked by out_valid; the receiver cannot stall.
// After each accept busy goes high and starts are ignored until it falls, a
// pace set by the single corner emitter; earlier segments may still be moving
// through the chains when the next one is accepted. A segment passes 3 input
// stages, a 32-cell square root chain, a FRAC_BITS + 1 cell divider chain,
// a shift stage, a product stage and the output register to its first corner.
// Write half_width and edge_cut only while no corner is due.
module segment_box_vertex_generator_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic               in_trim_start,
  input  logic               in_trim_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  output logic [2:0]         out_corner_index,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_last_corner
);
  import sbv_pkg::*;

  localparam int QW   = FRAC_BITS + 1;
  localparam int UW   = FRAC_BITS + 2;
  localparam int CW   = UW + 32;
  localparam int PW   = 34 + UW;
  localparam int SW   = PW + 2;
  localparam int SQ_N = 32;
  localparam logic signed [UW-1:0] ONE    = UW'(1) << FRAC_BITS;
  localparam logic [CW-1:0]        BIAS_C = (CW'(1) << FRAC_BITS) - CW'(1);
  localparam logic [SW-1:0]        BIAS_S = (SW'(1) << FRAC_BITS) - SW'(1);

  // ---------------- configuration ----------------
  logic [30:0] half_width_r;
  logic [30:0] edge_cut_r;

  assign cfg_ready = 1'b1;

  // Write a register on a completed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= 31'd65536;
      edge_cut_r   <= 31'd0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_HALF_WIDTH) begin
        half_width_r <= cfg_data[30:0];
      end else if (cfg_index == REG_EDGE_CUT) begin
        edge_cut_r <= cfg_data[30:0];
      end
    end
  end

  // ---------------- accept pacing ----------------
  logic       accept;
  logic [2:0] gap_r;

  assign accept = start && !busy;
  assign busy   = (gap_r != 3'd0);

  // Hold off the next segment while the gap counter runs down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 3'd0;
    end else if (accept) begin
      gap_r <= 3'd7;
    end else if (gap_r != 3'd0) begin
      gap_r <= gap_r - 3'd1;
    end
  end

  // ---------------- input stages ----------------
  logic        s0_vld_r, s1_vld_r, s2_vld_r;
  side_t       s0_side_r, s1_side_r, s2_side_r;
  logic [63:0] sqx_r, sqy_r, sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Capture the segment with magnitudes, square, then sum
  always_ff @(posedge clk) begin
    s0_side_r.sx     <= in_origin_x;
    s0_side_r.sy     <= in_origin_y;
    s0_side_r.neg_x  <= in_vec_x[31];
    s0_side_r.neg_y  <= in_vec_y[31];
    s0_side_r.ax     <= in_vec_x[31] ? (32'd0 - in_vec_x) : in_vec_x;
    s0_side_r.ay     <= in_vec_y[31] ? (32'd0 - in_vec_y) : in_vec_y;
    s0_side_r.trim_s <= in_trim_start;
    s0_side_r.trim_e <= in_trim_end;
    sqx_r            <= s0_side_r.ax * s0_side_r.ax;
    sqy_r            <= s0_side_r.ay * s0_side_r.ay;
    s1_side_r        <= s0_side_r;
    sum_r            <= sqx_r + sqy_r;
    s2_side_r        <= s1_side_r;
  end

  // ---------------- square root chain ----------------
  logic        sq_vld  [0:SQ_N];
  logic [63:0] sq_rad  [0:SQ_N];
  logic [35:0] sq_rem  [0:SQ_N];
  logic [31:0] sq_root [0:SQ_N];
  side_t       sq_side [0:SQ_N];

  assign sq_vld[0]  = s2_vld_r;
  assign sq_rad[0]  = sum_r;
  assign sq_rem[0]  = 36'd0;
  assign sq_root[0] = 32'd0;
  assign sq_side[0] = s2_side_r;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    sbv_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[k]),
      .in_rad   (sq_rad[k]),
      .in_rem   (sq_rem[k]),
      .in_root  (sq_root[k]),
      .in_side  (sq_side[k]),
      .out_vld  (sq_vld[k+1]),
      .out_rad  (sq_rad[k+1]),
      .out_rem  (sq_rem[k+1]),
      .out_root (sq_root[k+1]),
      .out_side (sq_side[k+1])
    );
  end

  // ---------------- divider chain ----------------
  logic          dv_vld  [0:QW];
  logic [31:0]   dv_mag  [0:QW];
  logic [32:0]   dv_rx   [0:QW];
  logic [32:0]   dv_ry   [0:QW];
  logic [QW-1:0] dv_qx   [0:QW];
  logic [QW-1:0] dv_qy   [0:QW];
  side_t         dv_side [0:QW];

  assign dv_vld[0]  = sq_vld[SQ_N];
  assign dv_mag[0]  = sq_root[SQ_N];
  assign dv_rx[0]   = {1'b0, sq_side[SQ_N].ax};
  assign dv_ry[0]   = {1'b0, sq_side[SQ_N].ay};
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;
  assign dv_side[0] = sq_side[SQ_N];

  for (genvar k = 0; k < QW; k++) begin : g_div
    sbv_div_cell #(.QW(QW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (dv_vld[k]),
      .in_mag   (dv_mag[k]),
      .in_rx    (dv_rx[k]),
      .in_ry    (dv_ry[k]),
      .in_qx    (dv_qx[k]),
      .in_qy    (dv_qy[k]),
      .in_side  (dv_side[k]),
      .out_vld  (dv_vld[k+1]),
      .out_mag  (dv_mag[k+1]),
      .out_rx   (dv_rx[k+1]),
      .out_ry   (dv_ry[k+1]),
      .out_qx   (dv_qx[k+1]),
      .out_qy   (dv_qy[k+1]),
      .out_side (dv_side[k+1])
    );
  end

  // ---------------- unit vector, start shift and length ----------------
  side_t                    dv_o;
  logic                     mag_zero;
  logic signed [UW-1:0]     ux, uy;
  logic signed [CW-1:0]     cpx, cpy, cax, cay;
  logic signed [33:0]       cut34;
  logic signed [33:0]       sx_nxt, sy_nxt, len_nxt;

  logic                     s3_vld_r;
  logic signed [UW-1:0]     ux_r, uy_r;
  logic signed [33:0]       sx_r, sy_r, len_r;

  always_comb begin
    dv_o     = dv_side[QW];
    mag_zero = (dv_mag[QW] == 32'd0);
    ux = mag_zero ? ONE :
         (dv_o.neg_x ? -$signed({1'b0, dv_qx[QW]}) : $signed({1'b0, dv_qx[QW]}));
    uy = mag_zero ? '0 :
         (dv_o.neg_y ? -$signed({1'b0, dv_qy[QW]}) : $signed({1'b0, dv_qy[QW]}));
    cpx = CW'(ux) * $signed({(CW-31)'(0), edge_cut_r});
    cpy = CW'(uy) * $signed({(CW-31)'(0), edge_cut_r});
    // Truncate toward zero
    cax = (cpx + (cpx[CW-1] ? $signed(BIAS_C) : $signed(CW'(0)))) >>> FRAC_BITS;
    cay = (cpy + (cpy[CW-1] ? $signed(BIAS_C) : $signed(CW'(0)))) >>> FRAC_BITS;
    sx_nxt = 34'(dv_o.sx);
    sy_nxt = 34'(dv_o.sy);
    if (dv_o.trim_s && !mag_zero) begin
      sx_nxt = sx_nxt + cax[33:0];
      sy_nxt = sy_nxt + cay[33:0];
    end
    cut34   = $signed({3'b000, edge_cut_r});
    len_nxt = $signed({2'b00, dv_mag[QW]});
    if (dv_o.trim_s) begin
      len_nxt = len_nxt - cut34;
    end
    if (dv_o.trim_e) begin
      len_nxt = len_nxt - cut34;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    ux_r  <= ux;
    uy_r  <= uy;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    len_r <= len_nxt;
  end

  // ---------------- corner products ----------------
  logic signed [PW-1:0] p_ruy_r, p_rux_r, p_lux_r, p_luy_r;
  logic signed [33:0]   px_r, py_r;
  logic [30:0]          r_r;
  logic signed [PW-1:0] r_ext;

  assign r_ext = $signed({(PW-31)'(0), half_width_r});

  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      p_ruy_r <= r_ext * PW'(uy_r);
      p_rux_r <= r_ext * PW'(ux_r);
      p_lux_r <= PW'(len_r) * PW'(ux_r);
      p_luy_r <= PW'(len_r) * PW'(uy_r);
      px_r    <= sx_r;
      py_r    <= sy_r;
      r_r     <= half_width_r;
    end
  end

  // ---------------- corner emitter ----------------
  logic       act_r;
  logic [2:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= 3'd0;
    end else if (s3_vld_r) begin
      act_r <= 1'b1;
      cnt_r <= 3'd0;
    end else if (act_r) begin
      act_r <= (cnt_r != 3'd7);
      cnt_r <= cnt_r + 3'd1;
    end
  end

  logic signed [SW-1:0] sum_x, sum_y, tx, ty, vx, vy;
  logic signed [31:0]   cx, cy, cz;

  // Form one corner: rotate, truncate, translate, saturate
  always_comb begin
    sum_x = cnt_r[0] ? -SW'(p_ruy_r) : SW'(p_ruy_r);
    sum_y = cnt_r[0] ? SW'(p_rux_r) : -SW'(p_rux_r);
    if (cnt_r[2]) begin
      sum_x = sum_x + SW'(p_lux_r);
      sum_y = sum_y + SW'(p_luy_r);
    end
    tx = (sum_x + (sum_x[SW-1] ? $signed(BIAS_S) : $signed(SW'(0)))) >>> FRAC_BITS;
    ty = (sum_y + (sum_y[SW-1] ? $signed(BIAS_S) : $signed(SW'(0)))) >>> FRAC_BITS;
    vx = tx + SW'(px_r);
    vy = ty + SW'(py_r);
    if ((~|vx[SW-1:31]) || (&vx[SW-1:31])) begin
      cx = vx[31:0];
    end else begin
      cx = vx[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if ((~|vy[SW-1:31]) || (&vy[SW-1:31])) begin
      cy = vy[31:0];
    end else begin
      cy = vy[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    cz = cnt_r[1] ? -$signed({1'b0, r_r}) : $signed({1'b0, r_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    out_corner_index <= cnt_r;
    out_x            <= cx;
    out_y            <= cy;
    out_z            <= cz;
    out_last_corner  <= (cnt_r == 3'd7);
  end

  // ---------------- checks ----------------
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accept did not raise busy");

  a_corners_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_corner |=> out_valid &&
      (out_corner_index == $past(out_corner_index) + 3'd1))
    else $error("corner run broken");

  a_run_restarts_at_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_corner |=> !out_valid || (out_corner_index == 3'd0))
    else $error("new run not at corner zero");

  a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> !act_r || (cnt_r == 3'd7))
    else $error("segment arrived while corners pending");

endmodule

// ===== hw/rtl/sbv_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
`timescale 1ns / 1ps
module sbv_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [63:0]   in_rad,
  input  logic [35:0]   in_rem,
  input  logic [31:0]   in_root,
  input  sbv_pkg::side_t in_side,
  output logic          out_vld,
  output logic [63:0]   out_rad,
  output logic [35:0]   out_rem,
  output logic [31:0]   out_root,
  output sbv_pkg::side_t out_side
);
  import sbv_pkg::*;

  logic        vld_r;
  logic [63:0] rad_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  side_t       side_r;

  logic [35:0] rem_s;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] rem_nxt;
  logic [31:0] root_nxt;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_s    = {in_rem[33:0], in_rad[63:62]};
    trial    = {2'b00, in_root, 2'b01};
    ge       = (rem_s >= trial);
    rem_nxt  = ge ? (rem_s - trial) : rem_s;
    root_nxt = {in_root[30:0], ge};
  end

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    rad_r  <= {in_rad[61:0], 2'b00};
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule

// ===== hw/rtl/sbv_div_cell.sv =====
// One quotient bit cell of the two lane restoring divider chain.
`timescale 1ns / 1ps
module sbv_div_cell #(
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [31:0]   in_mag,
  input  logic [32:0]   in_rx,
  input  logic [32:0]   in_ry,
  input  logic [QW-1:0] in_qx,
  input  logic [QW-1:0] in_qy,
  input  sbv_pkg::side_t in_side,
  output logic          out_vld,
  output logic [31:0]   out_mag,
  output logic [32:0]   out_rx,
  output logic [32:0]   out_ry,
  output logic [QW-1:0] out_qx,
  output logic [QW-1:0] out_qy,
  output sbv_pkg::side_t out_side
);
  import sbv_pkg::*;

  logic          vld_r;
  logic [31:0]   mag_r;
  logic [32:0]   rx_r;
  logic [32:0]   ry_r;
  logic [QW-1:0] qx_r;
  logic [QW-1:0] qy_r;
  side_t         side_r;

  logic        gx;
  logic        gy;
  logic [32:0] sub_x;
  logic [32:0] sub_y;

  // Compare, subtract, then shift the partial remainder for the next bit
  always_comb begin
    gx    = (in_rx >= {1'b0, in_mag});
    gy    = (in_ry >= {1'b0, in_mag});
    sub_x = gx ? (in_rx - {1'b0, in_mag}) : in_rx;
    sub_y = gy ? (in_ry - {1'b0, in_mag}) : in_ry;
  end

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    mag_r  <= in_mag;
    rx_r   <= {sub_x[31:0], 1'b0};
    ry_r   <= {sub_y[31:0], 1'b0};
    qx_r   <= {in_qx[QW-2:0], gx};
    qy_r   <= {in_qy[QW-2:0], gy};
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_mag  = mag_r;
  assign out_rx   = rx_r;
  assign out_ry   = ry_r;
  assign out_qx   = qx_r;
  assign out_qy   = qy_r;
  assign out_side = side_r;

endmodule
